[rtl/core/lmt3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt3_pkg
// Shared widths, codes and reset values of the 3x3 local-mean threshold unit.
// ----------------------------------------------------------------------------
package lmt3_pkg;

    localparam int MAX_SIZE_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int PIX_IN_W = 8;    // pixel field on the input channel
    localparam int POS_W    = 10;   // row and column fields of a result
    localparam int CFG_W    = 11;   // frame_size register

    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = CFG_W'(10);

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } t_action;

endpackage

[rtl/core/lmt3_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt3 channel interfaces
// Valid/ready channels for pixel items, threshold results and the
// frame_size write port.
// ----------------------------------------------------------------------------
interface lmt3_pix_if;
    logic                              valid;
    logic                              ready;
    lmt3_pkg::t_action                 action;
    logic [lmt3_pkg::PIX_IN_W-1:0]     pixel;

    modport source (output valid, output action, output pixel, input ready);
    modport sink   (input valid, input action, input pixel, output ready);
endinterface

interface lmt3_res_if;
    logic                              valid;
    logic                              ready;
    logic                              binary;
    logic [lmt3_pkg::POS_W-1:0]        row;
    logic [lmt3_pkg::POS_W-1:0]        column;
    logic                              frame_end;
    logic                              last_in_step;

    modport source (output valid, output binary, output row, output column,
                    output frame_end, output last_in_step, input ready);
    modport sink   (input valid, input binary, input row, input column,
                    input frame_end, input last_in_step, output ready);
endinterface

interface lmt3_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lmt3_pkg::CFG_W-1:0]        data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/local_mean_threshold_3x3_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3_unit
// Streaming 3x3 adaptive mean threshold over a square raster frame.
// ----------------------------------------------------------------------------
// Takes one item per clock, unless a stalled result channel or a frame_size
// write holds it off: a raster pixel or, once the frame is complete, a drain
// tick. Each pixel at row r, column c (r, c >= 1) yields the result for
// (r-1, c-1); the last pixel of a row also yields (r-1, last column), and
// drain tick d yields (last row, d). That row-closing item holds stage 2 for
// its second result, as both leave through the single output register. Each
// result passes stage 1, stage 2 and the output register in turn. Two line
// stores of MAX_SIZE words sit in synchronous memories, read when an item is
// taken and written back as it leaves stage 1, the write forwarded to a read
// of the same column in that cycle. The stores need no clearing: entries not
// yet written in the current frame only ever fall outside the neighbourhood
// mask. Writing frame_size (0 acts as 1, above MAX_SIZE as MAX_SIZE) restarts
// the frame; the pixel channel is held off in a cycle with a pending write.
// Pixels while draining and drain ticks outside draining are dropped.
// ----------------------------------------------------------------------------
module local_mean_threshold_3x3_unit #(
    parameter int MAX_SIZE   = lmt3_pkg::MAX_SIZE_DEF,
    parameter int PIXEL_BITS = lmt3_pkg::PIXEL_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lmt3_cfg_if.sink      i_cfg,
    lmt3_pix_if.sink      i_pix,
    lmt3_res_if.source    o_res
);

    localparam int AW    = $clog2(MAX_SIZE);
    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int SUM_W = PIXEL_BITS + 4;

    typedef logic [PIXEL_BITS-1:0] t_win [3][3];

    typedef struct packed {
        logic                        has;       // at least one result
        logic                        two;       // row-closing pixel
        logic                        pix_item;  // pixel, else drain tick
        logic                        rok0;      // top row in frame
        logic                        cok0;      // left column in frame
        logic                        cok2;      // right column in frame
        logic [lmt3_pkg::POS_W-1:0]  row;
        logic [lmt3_pkg::POS_W-1:0]  col;
        logic                        fend;
    } t_tag;

    function automatic logic [SW-1:0] eff_size(input logic [lmt3_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return SW'(1);
        end
        if (v > MAX_SIZE) begin
            return SW'(MAX_SIZE);
        end
        return SW'(v);
    endfunction

    // centre * count > sum over the masked cells; centre is column 1 or 2
    function automatic logic judge(input t_win w, input logic [2:0] rm,
                                   input logic [2:0] cm, input logic ctr2);
        logic [SUM_W-1:0]      sum;
        logic [3:0]            cnt;
        logic [PIXEL_BITS-1:0] ctr;
        sum = '0;
        cnt = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (rm[i] && cm[j]) begin
                    sum = sum + SUM_W'(w[i][j]);
                    cnt = cnt + 4'd1;
                end
            end
        end
        ctr = ctr2 ? w[1][2] : w[1][1];
        return (SUM_W'(ctr) * SUM_W'(cnt)) > sum;
    endfunction

    // frame position state
    logic [SW-1:0]         r_size, n_size;
    logic [AW-1:0]         r_in_row, n_in_row;
    logic [AW-1:0]         r_in_col, n_in_col;
    logic [SW-1:0]         r_drain, n_drain;
    logic                  r_draining, n_draining;

    // line stores: A holds the row above, B the row two above
    logic [PIXEL_BITS-1:0] r_mem_a [MAX_SIZE];
    logic [PIXEL_BITS-1:0] r_mem_b [MAX_SIZE];
    logic [PIXEL_BITS-1:0] r_qa, r_qb;
    logic                  r_fwd;
    logic [PIXEL_BITS-1:0] r_fwd_a, r_fwd_b;

    // stage 1: memory read returns
    logic                  r_s1_vld;
    t_tag                  r_s1_tag, s1_tag;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [AW-1:0]         r_s1_addr, rd_addr;
    logic                  r_s1_first, s1_first;

    // stage 2: window registered, results issued
    logic                  r_s2_vld;
    t_tag                  r_s2_tag;
    logic                  r_s2_ph;
    t_win                  r_win;
    logic [PIXEL_BITS-1:0] r_save_a, r_save_b;

    logic                  r_out_vld;
    logic                  r_out_bin;
    logic [lmt3_pkg::POS_W-1:0] r_out_row, r_out_col;
    logic                  r_out_fend, r_out_last;

    logic                  cfg_wr, pix_acc, s1_load, s1_go, wr_en;
    logic                  out_free, s2_final, s2_emit, s2_done, adv;
    logic [SW-1:0]         size_m1;
    logic                  last_col, last_row, last_drain;
    logic [PIXEL_BITS-1:0] qa, qb;
    logic [2:0]            rmask, cmask;
    logic                  bin;

    assign cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign pix_acc = i_pix.valid && i_pix.ready;
    assign size_m1 = r_size - 1'b1;

    assign last_col   = (SW'(r_in_col) == size_m1);
    assign last_row   = (SW'(r_in_row) == size_m1);
    assign last_drain = (r_drain == size_m1);

    assign out_free = !r_out_vld || o_res.ready;
    assign s2_final = !r_s2_tag.two || r_s2_ph;
    assign s2_emit  = r_s2_vld && r_s2_tag.has && out_free;
    assign s2_done  = r_s2_vld && (!r_s2_tag.has || (out_free && s2_final));
    assign adv      = !r_s2_vld || s2_done;
    assign s1_go    = r_s1_vld && adv;
    assign wr_en    = s1_go && r_s1_tag.pix_item;

    assign i_cfg.ready = 1'b1;
    // a frame_size write goes first; the item waits while it is pending
    assign i_pix.ready = (!r_s1_vld || adv) && !i_cfg.valid;

    assign qa = r_fwd ? r_fwd_a : r_qa;
    assign qb = r_fwd ? r_fwd_b : r_qb;

    // item decode and frame position
    always_comb begin
        n_size     = r_size;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_drain    = r_drain;
        n_draining = r_draining;
        s1_load    = 1'b0;
        s1_tag     = '0;
        s1_first   = 1'b0;
        rd_addr    = r_in_col;
        if (cfg_wr) begin
            n_size     = eff_size(i_cfg.data);
            n_in_row   = '0;
            n_in_col   = '0;
            n_drain    = '0;
            n_draining = 1'b0;
        end else if (pix_acc) begin
            if (i_pix.action == lmt3_pkg::ACT_DRAIN) begin
                if (r_draining) begin
                    if (r_drain >= r_size) begin
                        n_in_row   = '0;
                        n_in_col   = '0;
                        n_drain    = '0;
                        n_draining = 1'b0;
                    end else begin
                        s1_load         = 1'b1;
                        s1_first        = (r_drain == '0);
                        s1_tag.has      = 1'b1;
                        s1_tag.two      = 1'b0;
                        s1_tag.pix_item = 1'b0;
                        s1_tag.rok0     = (size_m1 != '0);
                        s1_tag.cok0     = (r_drain != '0);
                        s1_tag.cok2     = !last_drain;
                        s1_tag.row      = lmt3_pkg::POS_W'(size_m1);
                        s1_tag.col      = lmt3_pkg::POS_W'(r_drain);
                        s1_tag.fend     = last_drain;
                        rd_addr         = last_drain ? '0 : AW'(r_drain + 1'b1);
                        if (last_drain) begin
                            n_in_row   = '0;
                            n_in_col   = '0;
                            n_drain    = '0;
                            n_draining = 1'b0;
                        end else begin
                            n_drain = SW'(r_drain + 1'b1);
                        end
                    end
                end
            end else if (!r_draining) begin
                s1_load         = 1'b1;
                s1_first        = (r_in_col == '0);
                s1_tag.has      = (r_in_row != '0) && (r_in_col != '0);
                s1_tag.two      = (r_in_row != '0) && (r_in_col != '0) && last_col;
                s1_tag.pix_item = 1'b1;
                s1_tag.rok0     = (r_in_row > AW'(1));
                s1_tag.cok0     = (r_in_col > AW'(1));
                s1_tag.cok2     = 1'b1;
                s1_tag.row      = lmt3_pkg::POS_W'(r_in_row - 1'b1);
                s1_tag.col      = lmt3_pkg::POS_W'(r_in_col - 1'b1);
                s1_tag.fend     = 1'b0;
                rd_addr         = r_in_col;
                if (last_col) begin
                    n_in_col = '0;
                    if (last_row) begin
                        n_in_row   = '0;
                        n_draining = 1'b1;
                        n_drain    = '0;
                    end else begin
                        n_in_row = r_in_row + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= eff_size(lmt3_pkg::FRAME_SIZE_RST);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_drain    <= '0;
            r_draining <= 1'b0;
        end else begin
            r_size     <= n_size;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_drain    <= n_drain;
            r_draining <= n_draining;
        end
    end

    // line stores: read on take, write back as the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_a[r_s1_addr] <= r_s1_pix;
            r_mem_b[r_s1_addr] <= qa;
        end
        if (s1_load) begin
            r_qa <= r_mem_a[rd_addr];
            r_qb <= r_mem_b[rd_addr];
        end
    end

    // same-column write in the read cycle wins over the stale read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (s1_load) begin
            r_fwd <= wr_en && (r_s1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_fwd_a    <= r_s1_pix;
            r_fwd_b    <= qa;
            r_s1_tag   <= s1_tag;
            r_s1_pix   <= PIXEL_BITS'(i_pix.pixel);
            r_s1_addr  <= rd_addr;
            r_s1_first <= s1_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s2_ph  <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_s2_vld <= 1'b1;
            end else if (s2_done) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_emit && !s2_final) begin
                r_s2_ph <= 1'b1;
            end else if (s2_done) begin
                r_s2_ph <= 1'b0;
            end
        end
    end

    // window shift; the first drain tick reloads column 0 of the last row
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_tag <= r_s1_tag;
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= qb;
            r_win[1][2] <= qa;
            if (r_s1_tag.pix_item) begin
                r_win[2][2] <= r_s1_pix;
                if (r_s1_first) begin
                    r_save_b <= qa;
                    r_save_a <= r_s1_pix;
                end
            end else begin
                r_win[2][2] <= '0;
                if (r_s1_first) begin
                    r_win[0][1] <= r_save_b;
                    r_win[1][1] <= r_save_a;
                end
            end
        end
    end

    assign rmask = {r_s2_tag.pix_item, 1'b1, r_s2_tag.rok0};
    assign cmask = r_s2_ph ? 3'b110 : {r_s2_tag.cok2, 1'b1, r_s2_tag.cok0};
    assign bin   = judge(r_win, rmask, cmask, r_s2_ph);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit) begin
            r_out_bin  <= bin;
            r_out_row  <= r_s2_tag.row;
            r_out_col  <= r_s2_ph ? lmt3_pkg::POS_W'(r_s2_tag.col + 1'b1) : r_s2_tag.col;
            r_out_fend <= r_s2_tag.fend;
            r_out_last <= s2_final;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.binary       = r_out_bin;
    assign o_res.row          = r_out_row;
    assign o_res.column       = r_out_col;
    assign o_res.frame_end    = r_out_fend;
    assign o_res.last_in_step = r_out_last;

    // frame end only comes from a drain tick, which has a single result
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_fend |-> r_out_last)
        else $error("frame end result not last of its item");

    // second result only for a row-closing pixel
    a_ph_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_ph |-> r_s2_vld && r_s2_tag.two && r_s2_tag.pix_item)
        else $error("second result phase on wrong item");

    // after the first of two results the item stays for the second
    a_ph_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_emit && !s2_final |=> r_s2_vld && r_s2_ph)
        else $error("row-closing item left before its second result");

    // drain position stays inside the frame, pixel position parked
    a_drain_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_drain < r_size) && (r_in_row == '0) && (r_in_col == '0))
        else $error("drain position out of frame");

    // line-store write only as a pixel item leaves stage 1
    a_wr_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_s1_vld && adv && SW'(r_s1_addr) < r_size)
        else $error("line store written outside a pixel item");

endmodule

[test/lmt3_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmt3_checker
// Watches the config, pixel and result channels of the 3x3 local-mean
// threshold unit. It keeps its own copy of the line stores, the window and the
// raster position, predicts the results of every accepted item and compares
// each accepted result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module lmt3_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lmt3_cfg_if  i_cfg,
    lmt3_pix_if  i_pix,
    lmt3_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int MAX_SIDE    = lmt3_pkg::MAX_SIZE_DEF;
    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic                       binary;
        logic [lmt3_pkg::POS_W-1:0] row;
        logic [lmt3_pkg::POS_W-1:0] column;
        logic                       frame_end;
        logic                       last_in_step;
    } t_threshold_result;

    t_threshold_result due_results[$];

    logic [lmt3_pkg::CFG_W-1:0]    size_reg;
    logic [lmt3_pkg::PIX_IN_W-1:0] line_above  [MAX_SIDE];
    logic [lmt3_pkg::PIX_IN_W-1:0] line_above2 [MAX_SIDE];
    logic [2:0][2:0][lmt3_pkg::PIX_IN_W-1:0] nbhd;
    int                        in_row;
    int                        in_col;
    int                        drain_col;
    bit                        draining;

    int fail_count    = 0;
    int pending_count = 0;
    int checked_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    function automatic int frame_side(input logic [lmt3_pkg::CFG_W-1:0] value);
        if (value == '0) return 1;
        if (value > MAX_SIDE) return MAX_SIDE;
        return int'(value);
    endfunction

    // centre cell against the sum of the cells inside the frame, no division
    function automatic logic above_mean(
            input logic [2:0][2:0][lmt3_pkg::PIX_IN_W-1:0] grid,
            input logic [2:0] rok, input logic [2:0] cok);
        int unsigned total;
        int unsigned count;
        total = 0;
        count = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (rok[i] && cok[j]) begin
                    total += grid[i][j];
                    count++;
                end
            end
        end
        return (grid[1][1] * count > total);
    endfunction

    function automatic t_threshold_result make_result(input logic bit_out, input int r,
                                                      input int c, input logic fend,
                                                      input logic last);
        t_threshold_result res;
        res.binary       = bit_out;
        res.row          = lmt3_pkg::POS_W'(r);
        res.column       = lmt3_pkg::POS_W'(c);
        res.frame_end    = fend;
        res.last_in_step = last;
        return res;
    endfunction

    function automatic void restart_frame();
        in_row    = 0;
        in_col    = 0;
        drain_col = 0;
        draining  = 1'b0;
    endfunction

    task automatic predict_thresholds(input lmt3_pkg::t_action act,
                                      input logic [lmt3_pkg::PIX_IN_W-1:0] value);
        int side;
        int r;
        int c;
        int d;
        int cc;
        logic [lmt3_pkg::PIX_IN_W-1:0] above1;
        logic [lmt3_pkg::PIX_IN_W-1:0] above2;
        logic [2:0][2:0][lmt3_pkg::PIX_IN_W-1:0] grid;
        logic [2:0] rok;
        logic [2:0] cok;

        side = frame_side(size_reg);
        if (act == lmt3_pkg::ACT_DRAIN) begin
            if (!draining) return;
            d = drain_col;
            if (d >= side) begin
                restart_frame();
                return;
            end
            // last row: rows above come from the stores, no row below
            for (int k = 0; k < 3; k++) begin
                cc = d + k;
                cok[k] = (cc >= 1) && (cc - 1 < side);
                if (cok[k]) begin
                    grid[0][k] = line_above2[cc-1];
                    grid[1][k] = line_above[cc-1];
                end else begin
                    grid[0][k] = '0;
                    grid[1][k] = '0;
                end
                grid[2][k] = '0;
            end
            rok = {1'b0, 1'b1, side >= 2};
            due_results.push_back(make_result(above_mean(grid, rok, cok), side - 1, d,
                                              d == side - 1, 1'b1));
            d++;
            if (d >= side) restart_frame();
            else drain_col = d;
            return;
        end

        if (draining) return;
        if (in_row >= side || in_col >= side) begin
            in_row = 0;
            in_col = 0;
        end
        r = in_row;
        c = in_col;
        above2 = line_above2[c];
        above1 = line_above[c];
        for (int i = 0; i < 3; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = above2;
        nbhd[1][2] = above1;
        nbhd[2][2] = value;
        line_above2[c] = above1;
        line_above[c]  = value;

        if (r >= 1 && c >= 1) begin
            rok = {2'b11, r >= 2};
            cok = {2'b11, c >= 2};
            due_results.push_back(make_result(above_mean(nbhd, rok, cok), r - 1, c - 1,
                                              1'b0, c != side - 1));
            // row closing pixel also settles the last column of the row above
            if (c == side - 1) begin
                for (int i = 0; i < 3; i++) begin
                    grid[i][0] = nbhd[i][1];
                    grid[i][1] = nbhd[i][2];
                    grid[i][2] = '0;
                end
                due_results.push_back(make_result(above_mean(grid, rok, 3'b011), r - 1, c,
                                                  1'b0, 1'b1));
            end
        end

        c++;
        if (c >= side) begin
            c = 0;
            r++;
            if (r >= side) begin
                r = 0;
                draining  = 1'b1;
                drain_col = 0;
            end
        end
        in_row = r;
        in_col = c;
    endtask

    task automatic check_result(input t_threshold_result want);
        string where;
        where = $sformatf("result %0d for (%0d,%0d):", checked_count, want.row, want.column);
        if (i_res.binary !== want.binary)
            report_mismatch($sformatf("%s binary %b, want %b", where, i_res.binary,
                                      want.binary));
        if (i_res.row !== want.row)
            report_mismatch($sformatf("%s row %0d, want %0d", where, i_res.row, want.row));
        if (i_res.column !== want.column)
            report_mismatch($sformatf("%s column %0d, want %0d", where, i_res.column,
                                      want.column));
        if (i_res.frame_end !== want.frame_end)
            report_mismatch($sformatf("%s frame_end %b, want %b", where, i_res.frame_end,
                                      want.frame_end));
        if (i_res.last_in_step !== want.last_in_step)
            report_mismatch($sformatf("%s last_in_step %b, want %b", where,
                                      i_res.last_in_step, want.last_in_step));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = lmt3_pkg::FRAME_SIZE_RST;
            restart_frame();
            nbhd = '0;
            for (int k = 0; k < MAX_SIDE; k++) begin
                line_above[k]  = '0;
                line_above2[k] = '0;
            end
            due_results.delete();
        end else begin
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                size_reg = i_cfg.data;
                restart_frame();
            end
            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1) begin
                predict_thresholds(i_pix.action, i_pix.pixel);
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result for (%0d,%0d) with none outstanding",
                                              i_res.row, i_res.column));
                end else begin
                    check_result(due_results.pop_front());
                end
                checked_count++;
            end
        end
        pending_count = due_results.size();
    end

endmodule

[test/tb_local_mean_threshold_3x3_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_mean_threshold_3x3_unit
// Drives frames of pixels and drain ticks into the threshold unit under three
// idling regimes, with a long result hold-off, corner frame sizes and stray
// or cut-short item sequences; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_local_mean_threshold_3x3_unit;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int NOISE_PCT       = 8;
    localparam int PHASE_ITEMS     = 170;

    typedef enum int {
        TEX_UNIFORM,
        TEX_SMOOTH,
        TEX_EXTREME,
        TEX_FLAT
    } t_texture;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int tx_idle_pct   = 38;
    int rx_idle_pct   = 70;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int accepted_items = 0;
    int counted_items  = 0;
    int frames_sent    = 0;
    int cycle_count    = 0;

    int mismatches;
    int pending;
    int checked;

    lmt3_cfg_if cfg_if();
    lmt3_pix_if pix_if();
    lmt3_res_if res_if();

    local_mean_threshold_3x3_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    lmt3_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_if),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .o_fail_count (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 clk = ~clk;

    // entered and left at a falling edge
    task automatic push_item(input lmt3_pkg::t_action act,
                             input logic [lmt3_pkg::PIX_IN_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.valid  = 1'b1;
        pix_if.action = act;
        pix_if.pixel  = value;
        @(posedge clk);
        while (pix_if.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        accepted_items++;
    endtask

    task automatic wait_until_idle();
        pix_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        // pixels in the first row or column leave nothing to wait for
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame_size(input logic [lmt3_pkg::CFG_W-1:0] value);
        wait_until_idle();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [lmt3_pkg::PIX_IN_W-1:0] pick_pixel(
            input t_texture tex, input int r, input int c,
            input logic [lmt3_pkg::PIX_IN_W-1:0] level);
        case (tex)
            TEX_UNIFORM: return lmt3_pkg::PIX_IN_W'($urandom_range(0, 255));
            TEX_SMOOTH:  return lmt3_pkg::PIX_IN_W'(level + r * 9 + c * 5 +
                                                    $urandom_range(0, 6));
            TEX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:     return level;
        endcase
    endfunction

    // cut >= 0 stops the frame after that many items
    task automatic send_frame(input int side, input t_texture tex, input int cut);
        int sent;
        logic [lmt3_pkg::PIX_IN_W-1:0] level;
        sent  = 0;
        level = lmt3_pkg::PIX_IN_W'($urandom_range(0, 255));
        for (int r = 0; r < side; r++) begin
            for (int c = 0; c < side; c++) begin
                if (cut >= 0 && sent >= cut) return;
                if ($urandom_range(0, 99) < NOISE_PCT)
                    push_item(lmt3_pkg::ACT_DRAIN,
                              lmt3_pkg::PIX_IN_W'($urandom_range(0, 255)));
                push_item(lmt3_pkg::ACT_PIXEL, pick_pixel(tex, r, c, level));
                sent++;
                counted_items++;
            end
        end
        for (int d = 0; d < side; d++) begin
            if (cut >= 0 && sent >= cut) return;
            if ($urandom_range(0, 99) < NOISE_PCT)
                push_item(lmt3_pkg::ACT_PIXEL,
                          lmt3_pkg::PIX_IN_W'($urandom_range(0, 255)));
            push_item(lmt3_pkg::ACT_DRAIN, lmt3_pkg::PIX_IN_W'($urandom_range(0, 255)));
            sent++;
            counted_items++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                stall_left    = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
                 pending);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int side;
        int cut;
        bit need_write;
        t_texture tex;

        pix_if.valid  = 1'b0;
        pix_if.action = lmt3_pkg::ACT_PIXEL;
        pix_if.pixel  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // frame at the reset size
        send_frame(10, TEX_UNIFORM, -1);
        frames_sent++;

        // zero size acts as a single pixel; stray items either side of it
        write_frame_size(11'd0);
        push_item(lmt3_pkg::ACT_DRAIN, 8'h00);
        push_item(lmt3_pkg::ACT_PIXEL, 8'hFF);
        push_item(lmt3_pkg::ACT_PIXEL, 8'h00);
        push_item(lmt3_pkg::ACT_DRAIN, 8'hFF);
        write_frame_size(11'd2);
        for (int k = 0; k < 4; k++)
            push_item(lmt3_pkg::ACT_PIXEL, (k == 1 || k == 2) ? 8'hFF : 8'h00);
        repeat (2) push_item(lmt3_pkg::ACT_DRAIN, 8'h5A);
        write_frame_size(11'd3);
        for (int k = 0; k < 9; k++) push_item(lmt3_pkg::ACT_PIXEL, k[0] ? 8'h00 : 8'hFF);
        repeat (3) push_item(lmt3_pkg::ACT_DRAIN, 8'hA5);
        frames_sent += 3;

        side       = 3;
        need_write = 1'b0;
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct   = (phase == 0) ? 38 : (phase == 1) ? 70 : 0;
            rx_idle_pct   = (phase == 0) ? 70 : (phase == 1) ? 38 : 0;
            counted_items = 0;
            if (phase == 2) begin
                // results held back while pixels keep coming: input must stall
                side = 12;
                write_frame_size(lmt3_pkg::CFG_W'(side));
                hold_off_req = 1'b1;
                send_frame(side, TEX_UNIFORM, -1);
                frames_sent++;
            end
            while (counted_items < PHASE_ITEMS) begin
                if (need_write || $urandom_range(0, 99) < 60) begin
                    side = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(1, 14);
                    write_frame_size(lmt3_pkg::CFG_W'(side));
                end
                cut = ($urandom_range(0, 99) < 12) ? $urandom_range(0, side * side + side - 1)
                                                   : -1;
                need_write = (cut >= 0);
                tex = t_texture'($urandom_range(0, 3));
                send_frame(side, tex, cut);
                frames_sent++;
            end
        end

        wait_until_idle();
        $display("Run covered %0d accepted items in %0d frames of sides 1 to 14,",
                 accepted_items, frames_sent);
        $display("with stray and cut-short sequences, stalls and a long hold-off: %0d results",
                 checked);
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
